// ===== rtl/gbu_pkg.sv =====
// ============================================================================
// gbu_pkg
// Shared types and constants of the 2x gray bilinear upscaler.
// ============================================================================
package gbu_pkg;

    localparam int MAX_WIDTH_DEF = 2048;   // default line store depth
    localparam int MAX_HEIGHT    = 2048;   // height clamp
    localparam int PIX_W         = 8;      // gray sample width
    localparam int SRC_W         = 11;     // source row width carried downstream
    localparam int DIM_W         = 12;     // width of size registers and output coordinates
    localparam int COL_W         = DIM_W;  // source column, covers any clamped width
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 12;
    localparam int QUEUE_DEPTH   = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    // Output row/column phase relative to source position p:
    // HALF -> 2p-1 (interpolated), COPY -> 2p, EDGE -> 2p+1 (replicated)
    localparam logic [1:0] PH_HALF = 2'd0;
    localparam logic [1:0] PH_COPY = 2'd1;
    localparam logic [1:0] PH_EDGE = 2'd2;

    // Gray weights: (11R + 16G + 5B) >> 5
    localparam int GRAY_SUM_W = 13;
    localparam logic [4:0] W_RED  = 5'd11;
    localparam logic [4:0] W_BLUE = 5'd5;

    typedef struct packed {
        logic                  color_mode;
        logic [DIM_W-1:0]      frame_width;
        logic [DIM_W-1:0]      frame_height;
    } cfg_t;

    // One classified pixel: its gray value, its neighbours and its position.
    typedef struct packed {
        logic [PIX_W-1:0] d;        // this pixel
        logic [PIX_W-1:0] a;        // above-left
        logic [PIX_W-1:0] b;        // above
        logic [PIX_W-1:0] c;        // left
        logic [COL_W-1:0] col;
        logic [SRC_W-1:0] row;
        logic             last_c;
        logic             last_r;
    } q_entry_t;

endpackage

// ===== rtl/gbu_if.sv =====
// ============================================================================
// gbu_if
// Valid/ready channels for source pixels and upscaled result items.
// ============================================================================
interface gbu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic       inside_source;

    modport source (output valid, byte_zero, byte_one, byte_two, inside_source,
                    input ready);
    modport sink   (input valid, byte_zero, byte_one, byte_two, inside_source,
                    output ready);
endinterface

interface gbu_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  gray_out;
    logic [11:0] out_col;
    logic [11:0] out_row;
    logic        run_last;
    logic        frame_done;

    modport source (output valid, gray_out, out_col, out_row, run_last, frame_done,
                    input ready);
    modport sink   (input valid, gray_out, out_col, out_row, run_last, frame_done,
                    output ready);
endinterface

// ===== rtl/gbu_ram.sv =====
// ============================================================================
// gbu_ram
// Generic single-port RAM, registered read, read returns the old data.
// ============================================================================
module gbu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

// ===== rtl/gbu_front.sv =====
// ============================================================================
// gbu_front
// Accepts pixels, reduces to gray, tracks position, fetches the row above.
// ============================================================================
module gbu_front #(
    parameter int MAX_WIDTH = gbu_pkg::MAX_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gbu_pkg::cfg_t     cfg,
    input  logic              restart,
    gbu_in_if.sink            pixels,
    output gbu_pkg::q_entry_t push_entry,
    output logic              push,
    input  logic              q_full
);
    import gbu_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = XW + 1;
    localparam int CW = (WW > DIM_W) ? WW : DIM_W;

    logic [XW-1:0]     x_reg, x_next;
    logic [SRC_W-1:0]  y_reg, y_next;
    logic [PIX_W-1:0]  left_reg, left_next;
    logic [PIX_W-1:0]  ul_reg, ul_next;
    logic              s1_valid_reg, s1_valid_next;
    q_entry_t          s1_reg, s1_next;

    logic [CW-1:0]         fw_c, w_c;
    logic [WW-1:0]         w_eff;
    logic [DIM_W-1:0]      h_eff;
    logic                  last_c, last_r;
    logic [GRAY_SUM_W-1:0] gsum;
    logic [PIX_W-1:0]      gray;
    logic [PIX_W-1:0]      ram_rdata;
    logic [PIX_W-1:0]      b_val;
    logic                  accept;

    // effective window size
    always_comb
    begin
        fw_c = CW'(cfg.frame_width);
        if (cfg.frame_width == '0)
            w_c = CW'(1);
        else if (fw_c > CW'(MAX_WIDTH))
            w_c = CW'(MAX_WIDTH);
        else
            w_c = fw_c;
        w_eff = WW'(w_c);

        if (cfg.frame_height == '0)
            h_eff = DIM_W'(1);
        else if (cfg.frame_height > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = cfg.frame_height;

        last_c = (({1'b0, x_reg} + WW'(1)) == w_eff);
        last_r = (({1'b0, y_reg} + DIM_W'(1)) == h_eff);
    end

    // gray reduction
    always_comb
    begin
        gsum = (GRAY_SUM_W'(pixels.byte_two) * GRAY_SUM_W'(W_RED))
             + {1'b0, pixels.byte_one, 4'b0000}
             + (GRAY_SUM_W'(pixels.byte_zero) * GRAY_SUM_W'(W_BLUE));
        if (!pixels.inside_source)
            gray = '0;
        else if (cfg.color_mode)
            gray = gsum[GRAY_SUM_W-1:5];
        else
            gray = pixels.byte_zero;
    end

    assign push         = s1_valid_reg && !q_full;
    assign pixels.ready = !s1_valid_reg || !q_full;
    assign accept       = pixels.valid && pixels.ready;

    // row above: read old entry and overwrite with this pixel in one access
    gbu_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .en    (accept),
        .we    (accept),
        .addr  (x_reg),
        .wdata (gray),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        b_val        = (s1_reg.row == '0) ? '0 : ram_rdata;
        push_entry   = s1_reg;
        push_entry.b = b_val;
        push_entry.a = ul_reg;
    end

    always_comb
    begin
        x_next        = x_reg;
        y_next        = y_reg;
        left_next     = left_reg;
        ul_next       = ul_reg;
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;

        if (push)
        begin
            ul_next       = b_val;
            s1_valid_next = 1'b0;
        end

        if (accept)
        begin
            s1_valid_next  = 1'b1;
            s1_next.d      = gray;
            s1_next.a      = '0;
            s1_next.b      = '0;
            s1_next.c      = left_reg;
            s1_next.col    = COL_W'(x_reg);
            s1_next.row    = y_reg;
            s1_next.last_c = last_c;
            s1_next.last_r = last_r;
            left_next      = gray;
            if (last_c)
            begin
                x_next = '0;
                y_next = last_r ? '0 : y_reg + SRC_W'(1);
            end
            else
            begin
                x_next = x_reg + XW'(1);
            end
        end

        if (restart)
        begin
            x_next    = '0;
            y_next    = '0;
            left_next = '0;
            ul_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg        <= '0;
            y_reg        <= '0;
            left_reg     <= '0;
            ul_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            x_reg        <= x_next;
            y_reg        <= y_next;
            left_reg     <= left_next;
            ul_reg       <= ul_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

endmodule

// ===== rtl/gbu_queue.sv =====
// ============================================================================
// gbu_queue
// Small register FIFO of classified pixels between front and back.
// ============================================================================
module gbu_queue #(
    parameter int DEPTH = gbu_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gbu_pkg::q_entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output gbu_pkg::q_entry_t head,
    output logic              empty
);
    import gbu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    q_entry_t        slot_reg [DEPTH];
    logic [AW-1:0]   wr_reg, wr_next;
    logic [AW-1:0]   rd_reg, rd_next;
    logic [NW-1:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == NW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
        if (pop)
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + NW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/gbu_back.sv =====
// ============================================================================
// gbu_back
// Walks each pixel's output rows/cols, one result per cycle unless stalled.
// ============================================================================
module gbu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  gbu_pkg::q_entry_t head,
    input  logic              empty,
    output logic              pop,
    gbu_out_if.source         results
);
    import gbu_pkg::*;

    logic              busy_reg, busy_next;
    logic [1:0]        rp_reg, rp_next;
    logic [1:0]        cp_reg, cp_next;
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  gray_reg, gray_next;
    logic [DIM_W-1:0]  col_reg, col_next;
    logic [DIM_W-1:0]  row_reg, row_next;
    logic              rlast_reg, rlast_next;
    logic              fdone_reg, fdone_next;

    logic [1:0]        rp, cp, rend, cend;
    logic              emit, last;
    logic [PIX_W+1:0]  sum4;
    logic [PIX_W:0]    sum_bd, sum_cd;

    always_comb
    begin
        rp   = busy_reg ? rp_reg : ((head.row == '0) ? PH_COPY : PH_HALF);
        cp   = busy_reg ? cp_reg : ((head.col == '0) ? PH_COPY : PH_HALF);
        rend = head.last_r ? PH_EDGE : PH_COPY;
        cend = head.last_c ? PH_EDGE : PH_COPY;
        last = (rp == rend) && (cp == cend);
        emit = !empty && (!out_valid_reg || results.ready);
        pop  = emit && last;

        sum4   = (PIX_W+2)'(head.a) + (PIX_W+2)'(head.b)
               + (PIX_W+2)'(head.c) + (PIX_W+2)'(head.d);
        sum_bd = (PIX_W+1)'(head.b) + (PIX_W+1)'(head.d);
        sum_cd = (PIX_W+1)'(head.c) + (PIX_W+1)'(head.d);
    end

    always_comb
    begin
        busy_next      = busy_reg;
        rp_next        = rp_reg;
        cp_next        = cp_reg;
        out_valid_next = out_valid_reg;
        gray_next      = gray_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        rlast_next     = rlast_reg;
        fdone_next     = fdone_reg;

        if (results.ready)
            out_valid_next = 1'b0;

        if (emit)
        begin
            out_valid_next = 1'b1;
            if (rp == PH_HALF && cp == PH_HALF)
                gray_next = sum4[PIX_W+1:2];
            else if (rp == PH_HALF)
                gray_next = sum_bd[PIX_W:1];
            else if (cp == PH_HALF)
                gray_next = sum_cd[PIX_W:1];
            else
                gray_next = head.d;
            // 2x wraps at the 12-bit coordinate width
            col_next   = {head.col[COL_W-2:0], 1'b0} + DIM_W'(cp) - DIM_W'(1);
            row_next   = {head.row, 1'b0} + DIM_W'(rp) - DIM_W'(1);
            rlast_next = last;
            fdone_next = last && head.last_c && head.last_r;

            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                busy_next = 1'b1;
                if (cp == cend)
                begin
                    cp_next = (head.col == '0) ? PH_COPY : PH_HALF;
                    rp_next = rp + 2'd1;
                end
                else
                begin
                    cp_next = cp + 2'd1;
                    rp_next = rp;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rp_reg        <= PH_HALF;
            cp_reg        <= PH_HALF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rp_reg        <= rp_next;
            cp_reg        <= cp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gray_reg  <= gray_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        rlast_reg <= rlast_next;
        fdone_reg <= fdone_next;
    end

    assign results.valid      = out_valid_reg;
    assign results.gray_out   = gray_reg;
    assign results.out_col    = col_reg;
    assign results.out_row    = row_reg;
    assign results.run_last   = rlast_reg;
    assign results.frame_done = fdone_reg;

endmodule

// ===== rtl/gray_convert_bilinear_upscale_2x_unit.sv =====
// ============================================================================
// gray_convert_bilinear_upscale_2x_unit
// 2x bilinear upscaler with mono or BGR-to-gray input, top level.
// ============================================================================
// An item passes the front stage register and the queue; the back end then
//   gives one result per cycle while the queue holds an item and the output
//   is not stalled. Items have 1 to 9 results (4 if interior), so the output
//   port sets the sustained rate. The line store takes one access per item.
// Reset: control state clears at once; the line store holds no reset and
//   needs no clearing pass, since only entries written earlier in the frame
//   are read.
module gray_convert_bilinear_upscale_2x_unit #(
    parameter int MAX_WIDTH = gbu_pkg::MAX_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    gbu_in_if.sink                         pixels,
    gbu_out_if.source                      results,
    input  logic                           cfg_we,
    input  logic [gbu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbu_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gbu_pkg::*;

    // Structure:
    //   front  - takes one pixel per cycle unless held by a full queue, makes its
    //            gray value, steps the column/row counters and reads/writes the
    //            column's line store entry; its registered read adds the row above.
    //   queue  - a few classified items, so the front keeps accepting while
    //            the back walks the output pixels of earlier items.
    //   back   - one output pixel per cycle unless stalled, into an output register.

    cfg_t     cfg_reg, cfg_next;
    logic     restart;
    q_entry_t push_entry;
    q_entry_t head;
    logic     push, pop, q_full, q_empty;

    // Any write to a known register restarts the frame.
    always_comb
    begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COLOR_MODE:
                begin
                    cfg_next.color_mode = cfg_data[0];
                    restart             = 1'b1;
                end
                CFG_FRAME_WIDTH:
                begin
                    cfg_next.frame_width = cfg_data;
                    restart              = 1'b1;
                end
                CFG_FRAME_HEIGHT:
                begin
                    cfg_next.frame_height = cfg_data;
                    restart               = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;   // unmapped index: ignored
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_mode   <= 1'b0;
            cfg_reg.frame_width  <= DIM_W'(1);
            cfg_reg.frame_height <= DIM_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gbu_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .restart    (restart),
        .pixels     (pixels),
        .push_entry (push_entry),
        .push       (push),
        .q_full     (q_full)
    );

    gbu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty)
    );

    gbu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .empty   (q_empty),
        .pop     (pop),
        .results (results)
    );

endmodule

// ===== tb/gray_convert_bilinear_upscale_2x_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gray_convert_bilinear_upscale_2x_unit_tb
// Self-checking bench for the 2x gray bilinear upscaler. A behavioral
// predictor follows every accepted source pixel and queues the output pixels
// it must cause; a checker compares each output item field by field, in
// order. Directed tests cover reset state, mono and BGR gray, size clamps,
// register-write restart, oversized width, maximum height and output
// backpressure, then random frames with random idling on both channels.
// ============================================================================
module gray_convert_bilinear_upscale_2x_unit_tb;
    import gbu_pkg::*;

    // Index 3 of the register port maps to no register: no restart expected.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int DRAIN_CYCLES  = 8;      // well past an item's path to the output
    localparam int RANDOM_PIXELS = 180;
    localparam int CLAMP_PIXELS  = 40;

    typedef struct packed {
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic       inside_source;
    } src_pixel_t;

    typedef struct packed {
        logic [7:0]       gray_out;
        logic [DIM_W-1:0] out_col;
        logic [DIM_W-1:0] out_row;
        logic             run_last;
        logic             frame_done;
    } up_pixel_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gbu_in_if  pixels_if ();
    gbu_out_if results_if ();

    gray_convert_bilinear_upscale_2x_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixels_if),
        .results   (results_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Clock: 8 ns period
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: shadow registers, line of the row above, neighbours
    // and raster position. Mirrors what the block must hold.
    // ------------------------------------------------------------------------
    logic             cfg_color;
    logic [DIM_W-1:0] cfg_width;
    logic [DIM_W-1:0] cfg_height;
    logic [7:0]       line_above [0:MAX_WIDTH_DEF-1];
    int unsigned      left_sample;
    int unsigned      above_left_sample;
    int unsigned      col_pos;
    int unsigned      row_pos;

    up_pixel_t expected_up[$];    // output pixels still owed by the block

    // Bench control and bookkeeping
    bit src_idle;                 // sender draws random gaps per item
    bit sink_idle;                // receiver draws random stalls per item
    int sink_hold;                // long receiver hold-off, counted down by the sink
    int pixels_sent;
    int outputs_checked;
    int frames_seen;
    int mismatches;

    // Size registers: 0 acts as 1, anything above the limit as the limit.
    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] value, input int limit);
        if (value == 0)
            return 1;
        if (value > limit)
            return limit;
        return 32'(value);
    endfunction

    // Work out every output pixel one source pixel causes, in emit order
    // (rows ascending, then columns), and advance the raster position.
    function automatic void upscale_pixel(input src_pixel_t p);
        int unsigned w, h, x, y, d, a, b, c, v;
        int unsigned rows [3];
        int unsigned cols [3];
        bit          row_half [3];
        bit          col_half [3];
        int          nr, nc;
        bit          last_c, last_r;
        up_pixel_t   o;
        w = eff_dim(cfg_width, MAX_WIDTH_DEF);
        h = eff_dim(cfg_height, MAX_HEIGHT);
        x = (col_pos >= w) ? 0 : col_pos;
        y = (row_pos >= h) ? 0 : row_pos;

        // outside pixels read as black; BGR weighting is 11R + 16G + 5B
        if (!p.inside_source)
            d = 0;
        else if (cfg_color)
            d = ((11 * p.byte_two + 16 * p.byte_one + 5 * p.byte_zero) >> 5) & 8'hFF;
        else
            d = p.byte_zero;

        b = (y > 0) ? line_above[x] : 0;
        a = above_left_sample;
        c = left_sample;
        last_c = (x == w - 1);
        last_r = (y == h - 1);

        nr = 0;
        if (y > 0)
        begin
            rows[nr] = 2 * y - 1;
            row_half[nr] = 1'b1;
            nr++;
        end
        rows[nr] = 2 * y;
        row_half[nr] = 1'b0;
        nr++;
        if (last_r)
        begin
            rows[nr] = 2 * y + 1;       // bottom edge replicated
            row_half[nr] = 1'b0;
            nr++;
        end

        nc = 0;
        if (x > 0)
        begin
            cols[nc] = 2 * x - 1;
            col_half[nc] = 1'b1;
            nc++;
        end
        cols[nc] = 2 * x;
        col_half[nc] = 1'b0;
        nc++;
        if (last_c)
        begin
            cols[nc] = 2 * x + 1;       // right edge replicated, no wrap
            col_half[nc] = 1'b0;
            nc++;
        end

        for (int i = 0; i < nr; i++)
        begin
            for (int j = 0; j < nc; j++)
            begin
                if (row_half[i] && col_half[j])
                    v = (a + b + c + d) >> 2;
                else if (row_half[i])
                    v = (b + d) >> 1;
                else if (col_half[j])
                    v = (c + d) >> 1;
                else
                    v = d;
                o.gray_out   = v[7:0];
                o.out_col    = cols[j][DIM_W-1:0];
                o.out_row    = rows[i][DIM_W-1:0];
                o.run_last   = (i == nr - 1) && (j == nc - 1);
                o.frame_done = o.run_last && last_c && last_r;
                expected_up.push_back(o);
            end
        end

        above_left_sample = b;
        line_above[x]     = d[7:0];
        left_sample       = d;
        if (last_c)
        begin
            col_pos = 0;
            row_pos = last_r ? 0 : y + 1;
        end
        else
        begin
            col_pos = x + 1;
            row_pos = y;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Output checker: compare each accepted item with the oldest expectation.
    // ------------------------------------------------------------------------
    task automatic check_output();
        up_pixel_t got, want;
        got.gray_out   = results_if.gray_out;
        got.out_col    = results_if.out_col;
        got.out_row    = results_if.out_row;
        got.run_last   = results_if.run_last;
        got.frame_done = results_if.frame_done;
        outputs_checked++;
        if (got.frame_done)
            frames_seen++;
        if (expected_up.size() == 0)
        begin
            $error("unexpected output item: row %0d col %0d gray %0d",
                   got.out_row, got.out_col, got.gray_out);
            mismatches++;
            return;
        end
        want = expected_up.pop_front();
        if (got.gray_out !== want.gray_out)
        begin
            $error("gray_out: expected %0d, got %0d", want.gray_out, got.gray_out);
            mismatches++;
        end
        if (got.out_col !== want.out_col)
        begin
            $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
            mismatches++;
        end
        if (got.out_row !== want.out_row)
        begin
            $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
            mismatches++;
        end
        if (got.run_last !== want.run_last)
        begin
            $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
            mismatches++;
        end
        if (got.frame_done !== want.frame_done)
        begin
            $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
            mismatches++;
        end
    endtask

    // Receiver: ready driven at the falling edge, items taken at the rising
    // edge. A long hold-off (sink_hold) beats the per-item stall.
    initial
    begin : output_sink
        int stall;
        stall = 0;
        results_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                results_if.ready <= 1'b0;
                sink_hold--;
            end
            else if (stall > 0)
            begin
                results_if.ready <= 1'b0;
                stall--;
            end
            else
                results_if.ready <= 1'b1;
            @(posedge clk);
            if (rst_n && results_if.valid && results_if.ready)
            begin
                check_output();
                stall = sink_idle ? $urandom_range(0, 11) : 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one source pixel; returns at the rising edge that accepts it.
    // valid stays high on return so back-to-back items leave no bubble.
    task automatic send_pixel(input src_pixel_t p);
        int gap;
        gap = src_idle ? $urandom_range(0, 11) : 0;
        @(negedge clk);
        repeat (gap)
        begin
            pixels_if.valid <= 1'b0;
            @(negedge clk);
        end
        pixels_if.valid         <= 1'b1;
        pixels_if.byte_zero     <= p.byte_zero;
        pixels_if.byte_one      <= p.byte_one;
        pixels_if.byte_two      <= p.byte_two;
        pixels_if.inside_source <= p.inside_source;
        do
            @(posedge clk);
        while (!pixels_if.ready);
        upscale_pixel(p);
        pixels_sent++;
    endtask

    function automatic src_pixel_t make_pixel(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2, input logic in_src);
        src_pixel_t p;
        p.byte_zero     = b0;
        p.byte_one      = b1;
        p.byte_two      = b2;
        p.inside_source = in_src;
        return p;
    endfunction

    // Random byte biased toward the extremes.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic src_pixel_t rand_pixel();
        return make_pixel(rand_byte(), rand_byte(), rand_byte(), $urandom_range(0, 7) != 0);
    endfunction

    // Stop offering, wait for every owed output, then let the pipe settle.
    task automatic wait_idle();
        @(negedge clk);
        pixels_if.valid <= 1'b0;
        while (expected_up.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write; the shadow copy and the restart follow it.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        bit restarts;
        restarts = 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_COLOR_MODE:   cfg_color  = value[0];
            CFG_FRAME_WIDTH:  cfg_width  = value;
            CFG_FRAME_HEIGHT: cfg_height = value;
            default:          restarts   = 1'b0;
        endcase
        if (restarts)
        begin
            col_pos           = 0;
            row_pos           = 0;
            left_sample       = 0;
            above_left_sample = 0;
        end
    endtask

    task automatic configure(input logic color, input logic [DIM_W-1:0] width,
                             input logic [DIM_W-1:0] height);
        wait_idle();
        // upper bits of the mode write are don't-care
        set_reg(CFG_COLOR_MODE, {11'($urandom_range(0, 2047)), color});
        set_reg(CFG_FRAME_WIDTH, width);
        set_reg(CFG_FRAME_HEIGHT, height);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: mono, 1x1 window, so every pixel is a whole 2x2 frame.
    task automatic test_reset_state();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        send_pixel(make_pixel(8'hFF, 8'h00, 8'h00, 1'b1));
        send_pixel(make_pixel(8'h00, 8'hFF, 8'hFF, 1'b1));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));   // outside reads black
    endtask

    // Mono 3x2: interior, edge and corner interpolation with extreme values.
    task automatic test_mono_frame();
        configure(1'b0, 12'd3, 12'd2);
        send_pixel(make_pixel(8'hFF, 8'h12, 8'h34, 1'b1));
        send_pixel(make_pixel(8'h00, 8'hFF, 8'hFF, 1'b1));
        send_pixel(make_pixel(8'hAA, 8'h00, 8'h00, 1'b1));
        send_pixel(make_pixel(8'h55, 8'hA5, 8'h5A, 1'b1));
        send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 1'b1));
        send_pixel(make_pixel(8'h01, 8'hFF, 8'h00, 1'b1));
    endtask

    // BGR to gray: white, each primary alone, then a second frame that
    // follows without a register write (position wraps).
    task automatic test_color_mode();
        configure(1'b1, 12'd2, 12'd2);
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1));
        send_pixel(make_pixel(8'h00, 8'h00, 8'hFF, 1'b1));
        send_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 1'b1));
        send_pixel(make_pixel(8'hFF, 8'h00, 8'h00, 1'b1));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
        send_pixel(make_pixel(8'h5A, 8'hA5, 8'hC3, 1'b1));
    endtask

    // Zero sizes act as one; a write to the unmapped index keeps the
    // position; a real write mid-frame restarts it.
    task automatic test_size_limits();
        configure(1'b0, 12'd0, 12'd0);
        send_pixel(rand_pixel());
        send_pixel(rand_pixel());
        configure(1'b1, 12'd2, 12'd2);
        send_pixel(rand_pixel());
        wait_idle();
        set_reg(CFG_UNMAPPED, 12'hFFF);
        send_pixel(rand_pixel());
        send_pixel(rand_pixel());
        send_pixel(rand_pixel());
        send_pixel(rand_pixel());
        wait_idle();
        set_reg(CFG_FRAME_HEIGHT, 12'd2);
        repeat (4) send_pixel(rand_pixel());
    endtask

    // Width above the line store clamps to 2048: the start of that long
    // line runs back to back, cut short by the next register write.
    task automatic test_wide_line();
        configure(1'b0, 12'hFFF, 12'd1);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        repeat (CLAMP_PIXELS) send_pixel(rand_pixel());
    endtask

    // Maximum height, one column: the top of the tall column, cut short.
    task automatic test_tall_column();
        configure(1'b1, 12'd1, 12'd2048);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        repeat (CLAMP_PIXELS) send_pixel(rand_pixel());
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering:
    // the block must fill and push back on its input without losing items.
    task automatic test_backpressure();
        configure(1'($urandom_range(0, 1)), 12'd5, 12'd4);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        sink_hold = 300;
        repeat (20) send_pixel(rand_pixel());
        wait_idle();        // sender pauses until everything is out
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        repeat (20) send_pixel(rand_pixel());
    endtask

    // Random frames: mostly whole frames of small random size, some running
    // on into the next frame, some cut short by a register write, and now
    // and then a zero or oversized size register.
    task automatic test_random_frames();
        int sent, count, pick;
        int unsigned w, h;
        logic [DIM_W-1:0] w_reg, h_reg;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            if ($urandom_range(0, 7) != 0)
            begin
                pick  = $urandom_range(0, 15);
                w_reg = (pick < 14) ? DIM_W'($urandom_range(1, 16)) :
                        (pick == 14) ? 12'd0 : DIM_W'($urandom_range(2049, 4095));
                pick  = $urandom_range(0, 15);
                h_reg = (pick < 14) ? DIM_W'($urandom_range(1, 8)) :
                        (pick == 14) ? 12'd0 : DIM_W'($urandom_range(2049, 4095));
                configure(1'($urandom_range(0, 1)), w_reg, h_reg);
            end
            else
                wait_idle();
            src_idle  = $urandom_range(0, 3) != 0;
            sink_idle = $urandom_range(0, 3) != 0;
            w = eff_dim(cfg_width, MAX_WIDTH_DEF);
            h = eff_dim(cfg_height, MAX_HEIGHT);
            count = w * h;
            if (count > 64)
                count = $urandom_range(1, 60);
            else if ($urandom_range(0, 5) == 0)
                count = $urandom_range(1, count);
            else if ($urandom_range(0, 5) == 0)
                count = 2 * count;
            if (count > RANDOM_PIXELS - sent)
                count = RANDOM_PIXELS - sent;
            repeat (count) send_pixel(rand_pixel());
            sent += count;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = CFG_COLOR_MODE;
        cfg_data                = '0;
        pixels_if.valid         = 1'b0;
        pixels_if.byte_zero     = '0;
        pixels_if.byte_one      = '0;
        pixels_if.byte_two      = '0;
        pixels_if.inside_source = 1'b0;
        src_idle                = 1'b0;
        sink_idle               = 1'b0;
        sink_hold               = 0;
        pixels_sent             = 0;
        outputs_checked         = 0;
        frames_seen             = 0;
        mismatches              = 0;

        // predictor at reset values
        cfg_color  = 1'b0;
        cfg_width  = 12'd1;
        cfg_height = 12'd1;
        foreach (line_above[i])
            line_above[i] = 8'h00;
        left_sample       = 0;
        above_left_sample = 0;
        col_pos           = 0;
        row_pos           = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_mono_frame();
        test_color_mode();
        test_size_limits();
        test_wide_line();
        test_tall_column();
        test_backpressure();
        test_random_frames();
        wait_idle();

        $display("Sent %0d source pixels, checked %0d output pixels over %0d frame ends;",
                 pixels_sent, outputs_checked, frames_seen);
        $display("mono and BGR, sizes 1x1 up to clamped width and height, with stalls.");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin : watchdog
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
